### sv/stbs_pkg.sv
package stbs_pkg;

   localparam int INDEX_W = 6;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

### sv/sorted_table_binary_search.sv
// channel | dir | tdata (low bit up)                       | tuser
// req     | in  | entry_index[5:0], data_value[37:6], pad  | req_type (0 load, 1 search)
// rsp     | out | found[0], position[6:1], pad[7]           | -
// csr     | in  | entry_count[6:0] on csr_wr_data          | -
//
// A load request writes the table when accepted and gives no result.
// A search makes P probes before the next accept, P = probes made (at most
// floor(log2(min(entry_count, DEPTH))) + 1, so 7 for 64 entries); an empty range makes none.
// Each probe is one table read through the single read port.
// Synchronous active-high reset clears control state; entry_count resets to DEPTH, capped at 127.
// A stalled rsp keeps a finished search in ST_DONE until the output register is free; requests
// wait while a search is probing or held there, and loads are taken while idle.
module sorted_table_binary_search #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // entry_index[5:0], data_value[37:6], zero pad
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // found[0], position[6:1], zero pad
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic                                mem_wr_en;
   logic [AW-1:0]                       mem_wr_addr;
   logic [stbs_pkg::DATA_W-1:0]         mem_wr_data;
   logic [AW-1:0]                       mem_rd_addr;
   logic [stbs_pkg::DATA_W-1:0]         mem_rd_data;
   logic                                rsp_found;
   logic [stbs_pkg::INDEX_W-1:0]        rsp_position;

   stbs_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_index    (req_tdata[5:0]),
      .req_value    (req_tdata[37:6]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   stbs_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {1'b0, rsp_position, rsp_found};

   a_write_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (req_tready && req_tvalid && req_tuser == stbs_pkg::REQ_LOAD))
      else $error("table write outside an accepted load");

   a_miss_position_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[6:1] == '0))
      else $error("miss with nonzero position");

   a_search_blocks_next: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == stbs_pkg::REQ_SEARCH) |=> !req_tready)
      else $error("request taken while a search is running");

endmodule

### sv/stbs_table.sv
module stbs_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [stbs_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [stbs_pkg::DATA_W-1:0] rd_data
);

   logic [stbs_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [stbs_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/stbs_ctrl.sv
module stbs_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [stbs_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]  req_value,
   input  logic                                csr_wr_en,
   input  logic [stbs_pkg::COUNT_W-1:0]        csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]        rsp_position,
   output logic                                mem_wr_en,
   output logic [AW-1:0]                       mem_wr_addr,
   output logic [stbs_pkg::DATA_W-1:0]         mem_wr_data,
   output logic [AW-1:0]                       mem_rd_addr,
   input  logic signed [stbs_pkg::DATA_W-1:0]  mem_rd_data
);

   localparam int BW = AW + 2;
   localparam int NW = (BW > 8) ? BW : 8;
   localparam logic [stbs_pkg::COUNT_W-1:0] CountReset =
      stbs_pkg::COUNT_W'((DEPTH > 127) ? 127 : DEPTH);

   stbs_pkg::state_type state_ff, state_in;

   logic [stbs_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic signed [BW-1:0]               lo_ff, lo_in;
   logic signed [BW-1:0]               hi_ff, hi_in;
   logic [AW-1:0]                      mid_ff, mid_in;
   logic signed [stbs_pkg::DATA_W-1:0] key_ff, key_in;
   logic                               res_found_ff, res_found_in;
   logic [stbs_pkg::INDEX_W-1:0]       res_pos_ff, res_pos_in;
   logic                               out_valid_ff, out_valid_in;
   logic                               out_found_ff, out_found_in;
   logic [stbs_pkg::INDEX_W-1:0]       out_pos_ff, out_pos_in;

   logic                 req_fire;
   logic                 is_search;
   logic [NW-1:0]        count_sat;
   logic signed [BW-1:0] hi_init;
   logic                 init_empty;
   logic signed [BW-1:0] mid_ext;
   logic                 probe_eq;
   logic                 probe_lt;
   logic signed [BW-1:0] lo_nx;
   logic signed [BW-1:0] hi_nx;
   logic signed [BW-1:0] sum_nx;
   logic [AW-1:0]        mid_nx;
   logic                 probe_empty;
   logic                 probe_done;
   logic                 slot_free;

   assign req_fire   = req_valid & req_ready;
   assign is_search  = (req_kind == stbs_pkg::REQ_SEARCH);
   assign count_sat  = (NW'(count_ff) > NW'(DEPTH)) ? NW'(DEPTH) : NW'(count_ff);
   assign hi_init    = BW'(count_sat) - BW'(1);
   assign init_empty = (count_sat == '0);

   assign mid_ext     = BW'(mid_ff);
   assign probe_eq    = (mem_rd_data == key_ff);
   assign probe_lt    = (mem_rd_data < key_ff);
   assign lo_nx       = probe_lt ? (mid_ext + BW'(1)) : lo_ff;
   assign hi_nx       = probe_lt ? hi_ff : (mid_ext - BW'(1));
   assign sum_nx      = lo_nx + hi_nx;
   assign mid_nx      = sum_nx[AW:1];
   assign probe_empty = (lo_nx > hi_nx);
   assign probe_done  = probe_eq | probe_empty;
   assign slot_free   = ~out_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (req_fire && is_search) begin
               state_in = init_empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (probe_done) begin
               state_in = slot_free ? stbs_pkg::ST_IDLE : stbs_pkg::ST_DONE;
            end
         end
         stbs_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_addr  = mid_nx;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_found_in = out_found_ff;
      out_pos_in   = out_pos_ff;
      case (state_ff)
         stbs_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            mem_rd_addr = hi_init[AW:1];
            mem_wr_en   = req_fire & ~is_search & (32'(req_index) < 32'(DEPTH));
            if (req_fire && is_search) begin
               key_in       = req_value;
               lo_in        = '0;
               hi_in        = hi_init;
               mid_in       = hi_init[AW:1];
               res_found_in = 1'b0;
               res_pos_in   = '0;
            end
         end
         stbs_pkg::ST_PROBE: begin
            lo_in        = lo_nx;
            hi_in        = hi_nx;
            mid_in       = mid_nx;
            res_found_in = probe_eq;
            res_pos_in   = probe_eq ? stbs_pkg::INDEX_W'(mid_ff) : '0;
            if (probe_done && slot_free) begin
               out_valid_in = 1'b1;
               out_found_in = probe_eq;
               out_pos_in   = probe_eq ? stbs_pkg::INDEX_W'(mid_ff) : '0;
            end
         end
         stbs_pkg::ST_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_pos_in   = res_pos_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbs_pkg::ST_IDLE;
         count_ff     <= CountReset;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
   end

   assign mem_wr_addr  = AW'(req_index);
   assign mem_wr_data  = req_value;
   assign rsp_valid    = out_valid_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_position = out_pos_ff;

endmodule

### tb/testbench.sv
module testbench;

   typedef struct packed {
      logic       found;
      logic [5:0] position;
   } answer_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               req_type;
      logic [5:0]         index;
      logic signed [31:0] value;
      logic               typed;
      logic               found;
      logic [5:0]         position;
   } stim_row_type;

   localparam int DEPTH = 64;
   localparam int NUM_ROWS = 23;
   localparam int NUM_PHASES = 10;
   localparam int MIXED_PER_PHASE = 120;
   localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // entry_index[5:0], data_value[37:6], zero pad
   logic        req_tuser = 1'b0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // found[0], position[6:1], zero pad
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   logic signed [31:0] table_image [DEPTH];
   logic [6:0]         active_count = 7'd64;
   answer_type         pending_answers [$];
   int                 errors = 0;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 stall_left = 0;

   sorted_table_binary_search #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic answer_type binary_lookup(input logic signed [31:0] key);
      int         lo;
      int         hi;
      int         mid;
      int         span;
      answer_type a;
      a = '0;
      span = (active_count > DEPTH) ? DEPTH : int'(active_count);
      lo = 0;
      hi = span - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (table_image[mid] == key) begin
            a.found = 1'b1;
            a.position = 6'(mid);
            return a;
         end
         if (table_image[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return a;
   endfunction

   // on return the request has just been accepted and req_tvalid is still high
   task automatic send_request(input logic kind, input logic [5:0] index,
                               input logic signed [31:0] value,
                               input logic typed, input answer_type typed_answer);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, value, index};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (kind == stbs_pkg::REQ_LOAD) table_image[index] = value;
      else pending_answers.push_back(typed ? typed_answer : binary_lookup(value));
   endtask

   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [6:0] count);
      wait_for_answers();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_count = count;
      @(posedge clock);
   endtask

   task automatic reload_table(input int style);
      int vals [$];
      int order [$];
      for (int k = 0; k < DEPTH; k++) begin
         vals.push_back(style == 1 ? int'($urandom_range(0, 15)) - 8 : int'($urandom));
         order.push_back(k);
      end
      if (style != 3) vals.sort();
      if (style == 2) begin
         vals[0] = MIN_VAL;
         vals[DEPTH-1] = MAX_VAL;
      end
      order.shuffle();
      foreach (order[k])
         send_request(stbs_pkg::REQ_LOAD, 6'(order[k]), vals[order[k]], 1'b0, '0);
   endtask

   // loads mostly keep the table ascending; a few break the order on purpose
   task automatic mixed_request();
      int                 r;
      int                 j;
      int                 span;
      longint             lo_b;
      longint             hi_b;
      logic signed [31:0] v;
      r = $urandom_range(0, 99);
      span = (active_count > DEPTH) ? DEPTH : int'(active_count);
      j = (span == 0) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, span - 1);
      if (r < 20) begin
         j = $urandom_range(0, DEPTH - 1);
         lo_b = (j == 0) ? longint'(MIN_VAL) : longint'(table_image[j-1]);
         hi_b = (j == DEPTH - 1) ? longint'(MAX_VAL) : longint'(table_image[j+1]);
         if (lo_b > hi_b || $urandom_range(0, 99) < 30) v = $urandom;
         else v = 32'(lo_b + ({$urandom, $urandom} % (hi_b - lo_b + 1)));
         send_request(stbs_pkg::REQ_LOAD, 6'(j), v, 1'b0, '0);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) v = table_image[j];
         else if (r < 70) v = table_image[j] + ($urandom_range(0, 1) ? 1 : -1);
         else if (r < 85) v = $urandom;
         else if (r < 92) v = $urandom_range(0, 1) ? MIN_VAL : MAX_VAL;
         else v = int'($urandom_range(0, 15)) - 8;
         send_request(stbs_pkg::REQ_SEARCH, 6'($urandom), v, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response found=%0b position=%0d",
                     $time, rsp_tdata[0], rsp_tdata[6:1]);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $display("%0t: found mismatch, expected %0b actual %0b",
                        $time, want.found, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[6:1] !== want.position) begin
               $display("%0t: position mismatch, expected %0d actual %0d",
                        $time, want.position, rsp_tdata[6:1]);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type directed_rows [NUM_ROWS];
      stim_row_type row;
      int           phase_counts [NUM_PHASES];
      int           idle_levels [5];

      directed_rows = '{
         '{ROW_CSR, stbs_pkg::REQ_LOAD,   6'd0,  32'sd1,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd0,  MIN_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'h2A, MIN_VAL,        1'b1, 1'b1, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'h15, MAX_VAL,        1'b1, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'h3F, 32'sd0,         1'b1, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd63, MAX_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd1,  32'sd0,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd2,  MAX_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_CSR, stbs_pkg::REQ_LOAD,   6'd0,  32'sd3,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd0,  MAX_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd7,  32'sd0,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd9,  MIN_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd1,  -32'sd1,        1'b0, 1'b0, 6'd0},
         '{ROW_CSR, stbs_pkg::REQ_LOAD,   6'd0,  32'sd0,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd0,  32'sd0,         1'b1, 1'b0, 6'd0},
         '{ROW_CSR, stbs_pkg::REQ_LOAD,   6'd0,  32'sd2,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd1,  MIN_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd3,  MIN_VAL,        1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd4,  32'sd5,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_LOAD,   6'd2,  32'sh5555_5555, 1'b0, 1'b0, 6'd0},
         '{ROW_CSR, stbs_pkg::REQ_LOAD,   6'd0,  32'sd3,         1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd5,  32'sh5555_5555, 1'b0, 1'b0, 6'd0},
         '{ROW_REQ, stbs_pkg::REQ_SEARCH, 6'd6,  32'sh2AAA_AAAA, 1'b0, 1'b0, 6'd0}
      };
      phase_counts = '{64, 127, 1, 2, 65, 0, 33, 64, 64, 7};
      phase_counts[7] = $urandom_range(1, 64);
      idle_levels = '{0, 0, 15, 40, 80};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) write_entry_count(row.value[6:0]);
         else send_request(row.req_type, row.index, row.value, row.typed,
                           {row.found, row.position});
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = (p == 0) ? 0 : idle_levels[$urandom_range(0, 4)];
         rsp_stall_pct = (p == 0) ? 0 : idle_levels[$urandom_range(0, 4)];
         write_entry_count(7'(phase_counts[p]));
         if (p == 0) reload_table(0);
         else if ($urandom_range(0, 1)) reload_table($urandom_range(0, 3));
         for (int i = 0; i < MIXED_PER_PHASE; i++) begin
            if ($urandom_range(0, 59) == 0) wait_for_answers();
            mixed_request();
         end
      end

      wait_for_answers();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

### sorted_table_binary_search.f
sv/stbs_pkg.sv
sv/stbs_table.sv
sv/stbs_ctrl.sv
sv/sorted_table_binary_search.sv
tb/testbench.sv
